/* rtl/core/fctm_pkg.sv */
// Package for the four-corner tint modulator: widths, tint constants,
// configuration register indexes and the divide-by-255 helper.
// No dependencies.
package fctm_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam int POS_W     = 12;  // pixel coordinate
    localparam int DIM_W     = 13;  // rectangle dimension register
    localparam int SPAN_W    = 13;  // dimension minus one
    localparam int CH_W      = 8;   // one color byte
    localparam int NUM_W     = 20;  // |pos * delta|, below 2^20
    localparam int Q_W       = 8;   // quotient bits, |q| never above 255
    localparam int PROD_W    = 16;  // tint * pixel byte
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [31:0] NEUTRAL_TINT = 32'hFF80_8080;
    localparam logic [31:0] WHITE_TINT   = 32'hFFFF_FFFF;
    localparam logic [CH_W-1:0] CH_MAX   = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_LEFT     = 3'd0,
        CFG_TOP_RIGHT    = 3'd1,
        CFG_BOTTOM_RIGHT = 3'd2,
        CFG_BOTTOM_LEFT  = 3'd3,
        CFG_WIDTH        = 3'd4,
        CFG_HEIGHT       = 3'd5,
        CFG_HALF_SCALE   = 3'd6
    } cfg_idx_t;

    // Word carried alongside the vertical blend.
    typedef struct packed {
        logic             pass;
        logic [POS_W-1:0] pos_x;
        logic [31:0]      pix;   // blue, green, red, alpha from bit 0 up
    } vside_t;

    // Word carried alongside the horizontal blend.
    typedef struct packed {
        logic        pass;
        logic [31:0] pix;
    } hside_t;

    // Exact v / 255 for v up to 255 * 255 (any byte times byte product).
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] v);
        logic [PROD_W:0] acc;
        acc = {1'b0, v} + 17'd1 + {9'b0, v[15:8]};
        return acc[15:8];
    endfunction

endpackage

/* rtl/core/four_corner_tint_modulate_top.sv */
// Throughput: one word per cycle; every stage is elastic, so a stalled output
// holds only the words behind it and bubbles ahead of the stall still fill.
// Stages: edge multiply (1), vertical divider (8), row multiply (1),
// horizontal divider (8), tint multiply (1), scale/saturate (1).
// Reset (rst_n, async, active low) empties the pipe and loads the corners
// with the neutral tint, width, height and half-scale with zero.
module four_corner_tint_modulate_top
    import fctm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,   // pos_x, pos_y, in_blue, in_green,
                                             // in_red, in_alpha
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // out_blue, out_green, out_red,
                                             // out_alpha
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

    localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);

    // ------------------------------------------------------------------
    // Configuration registers. Written only while the pipe is idle (the user's
    // duty; the block does not enforce it), so every stage reads them live.
    // ------------------------------------------------------------------
    logic [31:0]       tl_reg, tr_reg, br_reg, bl_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic              half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_reg     <= NEUTRAL_TINT;
            tr_reg     <= NEUTRAL_TINT;
            br_reg     <= NEUTRAL_TINT;
            bl_reg     <= NEUTRAL_TINT;
            width_reg  <= '0;
            height_reg <= '0;
            half_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TOP_LEFT:     tl_reg     <= cfg_wdata;
                CFG_TOP_RIGHT:    tr_reg     <= cfg_wdata;
                CFG_BOTTOM_RIGHT: br_reg     <= cfg_wdata;
                CFG_BOTTOM_LEFT:  bl_reg     <= cfg_wdata;
                CFG_WIDTH:        width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_HEIGHT:       height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_HALF_SCALE:   half_reg   <= cfg_wdata[0];
                default:          ;  // unknown index: drop the write
            endcase
        end
    end

    // Clamp dimensions to the maximum, derive spans.
    logic [DIM_W-1:0]  w_cl, h_cl;
    logic [SPAN_W-1:0] span_x, span_y;
    logic              neutral;

    assign w_cl   = ({4'b0, width_reg}  > MAX_DIM_V) ? MAX_DIM_V[DIM_W-1:0] : width_reg;
    assign h_cl   = ({4'b0, height_reg} > MAX_DIM_V) ? MAX_DIM_V[DIM_W-1:0] : height_reg;
    assign span_x = w_cl - 1'b1;
    assign span_y = h_cl - 1'b1;

    // All-neutral or all-white corners leave every pixel untouched.
    assign neutral = ((tl_reg == NEUTRAL_TINT) && (tr_reg == NEUTRAL_TINT) &&
                      (br_reg == NEUTRAL_TINT) && (bl_reg == NEUTRAL_TINT)) ||
                     ((tl_reg & tr_reg & br_reg & bl_reg) == WHITE_TINT);

    // ------------------------------------------------------------------
    // Stage A: unpack the word, form |pos_y * (bottom - top)| for the left
    // edge (lanes 0-3) and the right edge (lanes 4-7).
    // ------------------------------------------------------------------
    logic [POS_W-1:0] in_x, in_y;
    logic [31:0]      in_pix;

    assign in_x   = s_tdata[11:0];
    assign in_y   = s_tdata[23:12];
    assign in_pix = s_tdata[55:24];

    logic                       a_valid_reg;
    logic [7:0][NUM_W-1:0]      a_num_reg;
    logic [7:0]                 a_neg_reg;
    logic [7:0][CH_W-1:0]       a_base_reg;
    vside_t                     a_side_reg;
    logic                       a_rdy;
    logic                       dv_in_ready;

    logic [7:0][CH_W-1:0]       e_from, e_to;
    logic [7:0][CH_W:0]         e_diff;
    logic [7:0][CH_W-1:0]       e_mag;
    vside_t                     a_side_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            e_from[k]   = tl_reg[8*k +: 8];
            e_to[k]     = bl_reg[8*k +: 8];
            e_from[4+k] = tr_reg[8*k +: 8];
            e_to[4+k]   = br_reg[8*k +: 8];
        end
        for (int l = 0; l < 8; l++)
        begin
            e_diff[l] = {1'b0, e_to[l]} - {1'b0, e_from[l]};
            e_mag[l]  = e_diff[l][CH_W] ? CH_W'(-e_diff[l]) : e_diff[l][CH_W-1:0];
        end
        a_side_next.pass  = neutral || ({1'b0, in_x} >= w_cl) || ({1'b0, in_y} >= h_cl);
        a_side_next.pos_x = in_x;
        a_side_next.pix   = in_pix;
    end

    assign a_rdy    = !a_valid_reg || dv_in_ready;
    assign s_tready = a_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_rdy)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && s_tvalid)
        begin
            for (int l = 0; l < 8; l++)
            begin
                a_num_reg[l]  <= in_y * e_mag[l];
                a_neg_reg[l]  <= e_diff[l][CH_W];
                a_base_reg[l] <= e_from[l];
            end
            a_side_reg <= a_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Vertical blend: divide by span_y, add to the top corner.
    // ------------------------------------------------------------------
    logic                      dv_out_valid;
    logic [7:0][CH_W-1:0]      dv_res;
    logic [$bits(vside_t)-1:0] dv_sb;
    vside_t                    dv_side;
    logic                      b_rdy;

    fctm_div #(
        .LANES (8),
        .SB_W  ($bits(vside_t))
    ) u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_ready  (dv_in_ready),
        .in_num    (a_num_reg),
        .in_neg    (a_neg_reg),
        .in_base   (a_base_reg),
        .in_sb     (a_side_reg),
        .span      (span_y),
        .out_valid (dv_out_valid),
        .out_ready (b_rdy),
        .out_res   (dv_res),
        .out_sb    (dv_sb)
    );

    assign dv_side = vside_t'(dv_sb);

    // ------------------------------------------------------------------
    // Stage B: |pos_x * (right - left)| for each tint channel.
    // ------------------------------------------------------------------
    logic                       b_valid_reg;
    logic [3:0][NUM_W-1:0]      b_num_reg;
    logic [3:0]                 b_neg_reg;
    logic [3:0][CH_W-1:0]       b_base_reg;
    hside_t                     b_side_reg;
    logic                       dh_in_ready;
    logic [3:0][CH_W:0]         r_diff;
    logic [3:0][CH_W-1:0]       r_mag;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            r_diff[k] = {1'b0, dv_res[4+k]} - {1'b0, dv_res[k]};
            r_mag[k]  = r_diff[k][CH_W] ? CH_W'(-r_diff[k]) : r_diff[k][CH_W-1:0];
        end
    end

    assign b_rdy = !b_valid_reg || dh_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_rdy)
            b_valid_reg <= dv_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (b_rdy && dv_out_valid)
        begin
            for (int k = 0; k < 4; k++)
            begin
                b_num_reg[k]  <= dv_side.pos_x * r_mag[k];
                b_neg_reg[k]  <= r_diff[k][CH_W];
                b_base_reg[k] <= dv_res[k];
            end
            b_side_reg.pass <= dv_side.pass;
            b_side_reg.pix  <= dv_side.pix;
        end
    end

    // ------------------------------------------------------------------
    // Horizontal blend: divide by span_x, add to the left-edge color.
    // ------------------------------------------------------------------
    logic                      dh_out_valid;
    logic [3:0][CH_W-1:0]      dh_res;
    logic [$bits(hside_t)-1:0] dh_sb;
    logic                      sc_in_ready;

    fctm_div #(
        .LANES (4),
        .SB_W  ($bits(hside_t))
    ) u_div_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_ready  (dh_in_ready),
        .in_num    (b_num_reg),
        .in_neg    (b_neg_reg),
        .in_base   (b_base_reg),
        .in_sb     (b_side_reg),
        .span      (span_x),
        .out_valid (dh_out_valid),
        .out_ready (sc_in_ready),
        .out_res   (dh_res),
        .out_sb    (dh_sb)
    );

    // ------------------------------------------------------------------
    // Modulate the pixel and drive the output register.
    // ------------------------------------------------------------------
    fctm_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dh_out_valid),
        .in_ready   (sc_in_ready),
        .tint       (dh_res),
        .side       (hside_t'(dh_sb)),
        .half_scale (half_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pix    (m_tdata)
    );

endmodule

/* rtl/core/fctm_div.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Adds the signed quotient to a base byte. Uses fctm_pkg.
module fctm_div
    import fctm_pkg::*;
#(
    parameter int LANES = 4,
    parameter int SB_W  = 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [LANES-1:0][NUM_W-1:0]      in_num,
    input  logic [LANES-1:0]                 in_neg,
    input  logic [LANES-1:0][CH_W-1:0]       in_base,
    input  logic [SB_W-1:0]                  in_sb,
    input  logic [SPAN_W-1:0]                span,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [LANES-1:0][CH_W-1:0]       out_res,
    output logic [SB_W-1:0]                  out_sb
);

    logic                          vld_reg  [1:Q_W];
    logic [Q_W+1:1]                rdy;
    logic [LANES-1:0][NUM_W-1:0]   rem_reg  [1:Q_W];
    logic [LANES-1:0][Q_W-1:0]     quo_reg  [1:Q_W];
    logic [LANES-1:0]              neg_reg  [1:Q_W];
    logic [LANES-1:0][CH_W-1:0]    base_reg [1:Q_W];
    logic [SB_W-1:0]               sb_reg   [1:Q_W];
    logic                          span_nz;

    assign span_nz      = (span != '0);
    assign rdy[Q_W+1]   = out_ready;
    assign in_ready     = rdy[1];

    for (genvar s = 1; s <= Q_W; s++) begin : g_stg
        localparam logic [Q_W-1:0] QBIT = Q_W'(1) << (Q_W - s);

        logic                          v_src;
        logic [LANES-1:0][NUM_W-1:0]   r_src;
        logic [LANES-1:0][Q_W-1:0]     q_src;
        logic [LANES-1:0]              n_src;
        logic [LANES-1:0][CH_W-1:0]    b_src;
        logic [SB_W-1:0]               sb_src;
        logic [NUM_W-1:0]              sub;
        logic [LANES-1:0][NUM_W-1:0]   r_next;
        logic [LANES-1:0][Q_W-1:0]     q_next;

        if (s == 1) begin : g_first
            assign v_src  = in_valid;
            assign r_src  = in_num;
            assign q_src  = '0;
            assign n_src  = in_neg;
            assign b_src  = in_base;
            assign sb_src = in_sb;
        end
        else begin : g_next
            assign v_src  = vld_reg[s-1];
            assign r_src  = rem_reg[s-1];
            assign q_src  = quo_reg[s-1];
            assign n_src  = neg_reg[s-1];
            assign b_src  = base_reg[s-1];
            assign sb_src = sb_reg[s-1];
        end

        assign sub    = {{(NUM_W-SPAN_W){1'b0}}, span} << (Q_W - s);
        assign rdy[s] = !vld_reg[s] || rdy[s+1];

        // Trial subtract; a zero span yields a zero quotient.
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (span_nz && (r_src[l] >= sub))
                begin
                    r_next[l] = r_src[l] - sub;
                    q_next[l] = q_src[l] | QBIT;
                end
                else
                begin
                    r_next[l] = r_src[l];
                    q_next[l] = q_src[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (rdy[s])
                vld_reg[s] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && v_src)
            begin
                rem_reg[s]  <= r_next;
                quo_reg[s]  <= q_next;
                neg_reg[s]  <= n_src;
                base_reg[s] <= b_src;
                sb_reg[s]   <= sb_src;
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign out_sb    = sb_reg[Q_W];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (neg_reg[Q_W][l])
                out_res[l] = base_reg[Q_W][l] - quo_reg[Q_W][l];
            else
                out_res[l] = base_reg[Q_W][l] + quo_reg[Q_W][l];
        end
    end

endmodule

/* rtl/core/fctm_scale.sv */
// Tint-times-pixel multiply, scale by 1/255 (colors by 1/128 saturated if
// half_scale) into the output register. Two elastic stages. Uses fctm_pkg.
module fctm_scale
    import fctm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3:0][CH_W-1:0]     tint,       // red, green, blue, alpha
    input  hside_t                   side,
    input  logic                     half_scale,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [31:0]              out_pix      // blue, green, red, alpha
);

    logic                        p_valid_reg;
    logic [3:0][PROD_W-1:0]      prod_reg;
    hside_t                      p_side_reg;
    logic                        o_valid_reg;
    logic [31:0]                 o_pix_reg;
    logic                        p_rdy;
    logic                        o_rdy;
    logic [3:0][CH_W-1:0]        pch;
    logic [3:0][CH_W-1:0]        sc;
    logic [31:0]                 o_pix_next;

    assign o_rdy    = !o_valid_reg || out_ready;
    assign p_rdy    = !p_valid_reg || o_rdy;
    assign in_ready = p_rdy;

    // Pixel byte that each tint lane scales.
    assign pch[0] = side.pix[23:16];
    assign pch[1] = side.pix[15:8];
    assign pch[2] = side.pix[7:0];
    assign pch[3] = side.pix[31:24];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (half_scale)
                sc[k] = prod_reg[k][15] ? CH_MAX : prod_reg[k][14:7];
            else
                sc[k] = div255(prod_reg[k]);
        end
        sc[3] = div255(prod_reg[3]);
        if (p_side_reg.pass)
            o_pix_next = p_side_reg.pix;
        else
            o_pix_next = {sc[3], sc[0], sc[1], sc[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_rdy)
                p_valid_reg <= in_valid;
            if (o_rdy)
                o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_rdy && in_valid)
        begin
            for (int k = 0; k < 4; k++)
                prod_reg[k] <= tint[k] * pch[k];
            p_side_reg <= side;
        end
        if (o_rdy && p_valid_reg)
            o_pix_reg <= o_pix_next;
    end

    assign out_valid = o_valid_reg;
    assign out_pix   = o_pix_reg;

endmodule

/* rtl/core/fctm_checker.sv */
// Port-level checks for the four-corner tint modulator, bound to the top
// level. Depends on four_corner_tint_modulate_top.
module fctm_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata
);

    // Hold the output word while the sink stalls.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed under stall");

    // Input backpressure only comes from a stalled, full output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output stall");

    // A ready sink keeps the whole pipe open.
    a_open_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input not ready while output ready");

endmodule

bind four_corner_tint_modulate_top fctm_checker u_fctm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
